>>> rtl/core/lpbc_pkg.sv
// shared types, constants and blink pattern functions for the long-press led blinker
// no dependencies; used by the channel interfaces and the top level
package lpbc_pkg;

  // configuration port
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LONG_PRESS_TICKS = 1'b0,
    REG_MODE_COUNT       = 1'b1
  } cfg_reg_t;

  // field and state widths
  localparam int HOLD_W  = 12;
  localparam int MCNT_W  = 3;
  localparam int MODE_W  = 2;
  localparam int PHASE_W = 10;

  localparam logic [HOLD_W-1:0] HOLD_MAX        = 12'd4095;
  localparam logic [HOLD_W-1:0] LONG_PRESS_RST  = 12'd800;
  localparam logic [MCNT_W-1:0] MODE_COUNT_RST  = 3'd4;
  localparam logic [MCNT_W-1:0] MODE_LAST       = 3'd3;

  // pattern timing in ticks
  localparam logic [PHASE_W-1:0] SLOW_HALF  = 10'd500;
  localparam logic [PHASE_W-1:0] MID_HALF   = 10'd150;
  localparam logic [PHASE_W-1:0] FAST_HALF  = 10'd70;
  localparam logic [PHASE_W-1:0] DBL_PULSE  = 10'd100;
  localparam logic [PHASE_W-1:0] DBL_GAP    = 10'd400;
  localparam logic [PHASE_W-1:0] SLOW_PER   = 10'd1000;
  localparam logic [PHASE_W-1:0] MID_PER    = 10'd300;
  localparam logic [PHASE_W-1:0] FAST_PER   = 10'd140;
  localparam logic [PHASE_W-1:0] DBL_PER    = 10'd700;

  typedef enum logic [MODE_W-1:0] {
    MODE_SLOW   = 2'd0,
    MODE_MID    = 2'd1,
    MODE_FAST   = 2'd2,
    MODE_DOUBLE = 2'd3
  } mode_t;

  function automatic logic [PHASE_W-1:0] pattern_period(input logic [MODE_W-1:0] mode);
    case (mode_t'(mode))
      MODE_SLOW: pattern_period = SLOW_PER;
      MODE_MID:  pattern_period = MID_PER;
      MODE_FAST: pattern_period = FAST_PER;
      default:   pattern_period = DBL_PER;
    endcase
  endfunction

  function automatic logic pattern_level(input logic [MODE_W-1:0] mode,
                                         input logic [PHASE_W-1:0] phase);
    case (mode_t'(mode))
      MODE_SLOW: pattern_level = (phase < SLOW_HALF);
      MODE_MID:  pattern_level = (phase < MID_HALF);
      MODE_FAST: pattern_level = (phase < FAST_HALF);
      default:   pattern_level = (phase < DBL_PULSE) ||
                                 ((phase >= 10'd200) && (phase < 10'd300));
    endcase
  endfunction

endpackage

>>> rtl/core/lpbc_if.sv
// valid/ready channel interfaces: button tick items in, led status items out
// depends on lpbc_pkg for field widths
interface lpbc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface lpbc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        led_on;
  logic [lpbc_pkg::MODE_W-1:0] current_mode;
  logic                        blink_active;

  modport source (output valid, output led_on, output current_mode,
                  output blink_active, input ready);
  modport sink   (input valid, input led_on, input current_mode,
                  input blink_active, output ready);
endinterface

>>> rtl/core/long_press_led_blink_controller.sv
// top level of the long-press led blinker: button tick in, led status out
// depends on lpbc_pkg and the channel interfaces in lpbc_if.sv
//
// usage
//   tick_in carries one item per millisecond tick: button_level, 0 pressed, 1 released.
//   result_out returns one item per tick: led_on, current_mode and blink_active,
//   all showing the state after that tick.
//   a short press (released before the long-press threshold) toggles blinking;
//   holding past long_press_ticks advances the mode once per press.
//   cfg_we/cfg_index/cfg_wdata write long_press_ticks (index 0) and mode_count
//   (index 1); write only while no item is in flight.
// timing
//   an item accepted at a clock edge shows on result_out right after that edge.
//   one item per cycle while result_out keeps up; the state update is a handful of counters
//   and compares feeding the state registers and the single result register.
// reset
//   rst (synchronous, active high) restores the register defaults (800, 4),
//   clears the hold, mode and phase state, marks the button released and
//   empties the result register.
// stall
//   tick_in.ready stays high while the result register is empty or being taken
//   in the same cycle; if result_out stalls with a result held, tick_in.ready
//   drops and no tick is taken until the result leaves.
module long_press_led_blink_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lpbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lpbc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  lpbc_in_if.sink                             tick_in,
  lpbc_out_if.source                          result_out
);

  // configuration registers
  logic [lpbc_pkg::HOLD_W-1:0]  long_press_ticks;
  logic [lpbc_pkg::MCNT_W-1:0]  mode_count;

  // tick state
  logic                          prev_button;
  logic [lpbc_pkg::HOLD_W-1:0]  hold_count;
  logic                          long_done;
  logic                          blink_enable;
  logic [lpbc_pkg::MODE_W-1:0]  mode_index;
  logic [lpbc_pkg::PHASE_W-1:0] phase_count;

  // result register
  logic                          out_valid;
  logic                          out_led;

  logic                          accept;
  logic                          btn;
  logic                          press;
  logic [lpbc_pkg::HOLD_W-1:0]  hold_count_next;
  logic                          long_done_next;
  logic                          fire;
  logic [lpbc_pkg::MCNT_W-1:0]  mode_inc;
  logic [lpbc_pkg::MODE_W-1:0]  mode_index_next;
  logic                          blink_enable_next;
  logic                          restart;
  logic [lpbc_pkg::PHASE_W-1:0] period;
  logic [lpbc_pkg::PHASE_W-1:0] phase_cur;
  logic [lpbc_pkg::PHASE_W:0]   phase_inc;
  logic [lpbc_pkg::PHASE_W-1:0] phase_count_next;
  logic                          led_next;

  // result register frees up when it is empty or drained this cycle
  assign tick_in.ready = !out_valid || result_out.ready;
  assign accept        = tick_in.valid && tick_in.ready;
  assign btn           = tick_in.button_level;

  always_comb begin
    press           = !btn && prev_button;
    hold_count_next = hold_count;
    long_done_next  = long_done;
    mode_index_next = mode_index;
    restart         = 1'b0;

    // hold counter: restart on the press tick, count while held until the long press fires, saturate
    if (press) begin
      hold_count_next = '0;
      long_done_next  = 1'b0;
    end else if (!btn && !long_done && (hold_count < lpbc_pkg::HOLD_MAX)) begin
      hold_count_next = hold_count + 1'b1;
    end

    // long press advances the mode once per press, wrapping at mode_count or past MODE_LAST
    fire     = !btn && !long_done_next && (hold_count_next > long_press_ticks);
    mode_inc = {1'b0, mode_index} + 1'b1;
    if (fire) begin
      if ((mode_inc >= mode_count) || (mode_inc > lpbc_pkg::MODE_LAST)) begin
        mode_index_next = '0;
      end else begin
        mode_index_next = mode_inc[lpbc_pkg::MODE_W-1:0];
      end
      restart        = (mode_index_next != mode_index);
      long_done_next = 1'b1;
    end

    // short press release toggles blinking
    blink_enable_next = blink_enable;
    if (btn && !prev_button && !long_done_next) begin
      blink_enable_next = !blink_enable;
      if (!blink_enable) begin
        restart = 1'b1;
      end
    end

    // pattern position: restart on enable or mode change, wrap at the period
    period           = lpbc_pkg::pattern_period(mode_index_next);
    phase_cur        = (restart || (phase_count >= period)) ? '0 : phase_count;
    phase_inc        = {1'b0, phase_cur} + 1'b1;
    led_next         = 1'b0;
    phase_count_next = '0;
    if (blink_enable_next) begin
      led_next = lpbc_pkg::pattern_level(mode_index_next, phase_cur);
      if (phase_inc < {1'b0, period}) begin
        phase_count_next = phase_inc[lpbc_pkg::PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= lpbc_pkg::LONG_PRESS_RST;
      mode_count       <= lpbc_pkg::MODE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (lpbc_pkg::cfg_reg_t'(cfg_index))
        lpbc_pkg::REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_wdata;
        lpbc_pkg::REG_MODE_COUNT:       mode_count <= cfg_wdata[lpbc_pkg::MCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_button  <= 1'b1;
      hold_count   <= '0;
      long_done    <= 1'b0;
      blink_enable <= 1'b0;
      mode_index   <= '0;
      phase_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        prev_button  <= btn;
        hold_count   <= hold_count_next;
        long_done    <= long_done_next;
        blink_enable <= blink_enable_next;
        mode_index   <= mode_index_next;
        phase_count  <= phase_count_next;
        out_valid    <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // led level has no reset; mode and enable come straight from state
  always_ff @(posedge clk) begin
    if (accept) begin
      out_led <= led_next;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.led_on       = out_led;
  assign result_out.current_mode = mode_index;
  assign result_out.blink_active = blink_enable;

`ifndef SYNTHESIS
  // phase is parked at zero while blinking is off
  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    !blink_enable |-> (phase_count == '0))
    else $error("phase_count nonzero while blinking is off");

  // phase always lies inside the current mode's period
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    blink_enable |-> (phase_count < lpbc_pkg::pattern_period(mode_index)))
    else $error("phase_count outside pattern period");

  // a held result blocks new ticks
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_out.ready) |-> !tick_in.ready)
    else $error("tick taken while result stalled");

  // led is dark whenever blinking is off
  a_led_dark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !blink_enable) |-> !out_led)
    else $error("led lit with blinking off");
`endif

endmodule

>>> test/lpbc_checker.sv
`timescale 1ns / 100ps
// checker for the long-press led blinker: mirrors the button, hold, mode and phase state
// from accepted ticks and register writes, and compares every result item in order
// depends on lpbc_pkg and the channel interfaces in lpbc_if.sv
module lpbc_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lpbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  lpbc_in_if                               tick_mon,
  lpbc_out_if                              result_mon,
  output int                               fail_count,
  output int                               pending
);
  import lpbc_pkg::*;

  typedef struct packed {
    logic              led;
    logic [MODE_W-1:0] mode;
    logic              active;
  } led_status_t;

  // mirrored registers and state
  logic [HOLD_W-1:0]  thresh;
  logic [MCNT_W-1:0]  n_modes;
  logic               btn_last;
  logic [HOLD_W-1:0]  held;
  logic               long_seen;
  logic               blinking;
  logic [MODE_W-1:0]  mode;
  logic [PHASE_W-1:0] phase;

  led_status_t status_q [$];
  int          results_seen;

  function automatic int period_of(input logic [MODE_W-1:0] m);
    case (mode_t'(m))
      MODE_SLOW: return int'(SLOW_PER);
      MODE_MID:  return int'(MID_PER);
      MODE_FAST: return int'(FAST_PER);
      default:   return int'(DBL_PER);
    endcase
  endfunction

  function automatic logic lit_at(input logic [MODE_W-1:0] m, input logic [PHASE_W-1:0] p);
    int q;
    q = int'(p);
    case (mode_t'(m))
      MODE_SLOW: return q < int'(SLOW_HALF);
      MODE_MID:  return q < int'(MID_HALF);
      MODE_FAST: return q < int'(FAST_HALF);
      default:   return (q < int'(DBL_PULSE)) ||
                        (q >= 2 * int'(DBL_PULSE) && q < 3 * int'(DBL_PULSE));
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
    fail_count++;
  endtask

  task automatic step_button(input logic b);
    logic        restart;
    logic        lit;
    int          nxt;
    int          per;
    led_status_t s;
    restart = 1'b0;
    lit = 1'b0;
    if (!b && btn_last) begin
      held = '0;
      long_seen = 1'b0;
    end else if (!b && !long_seen && held < HOLD_MAX) begin
      held = held + 1'b1;
    end
    // long press: advance once per press
    if (!b && !long_seen && held > thresh) begin
      nxt = int'(mode) + 1;
      if (nxt >= int'(n_modes) || nxt > int'(MODE_LAST)) nxt = 0;
      if (nxt != int'(mode)) restart = 1'b1;
      mode = nxt[MODE_W-1:0];
      long_seen = 1'b1;
    end
    // short press release toggles blinking
    if (b && !btn_last && !long_seen) begin
      blinking = !blinking;
      if (blinking) restart = 1'b1;
    end
    btn_last = b;
    if (blinking) begin
      per = period_of(mode);
      if (restart || int'(phase) >= per) phase = '0;
      lit = lit_at(mode, phase);
      phase = (int'(phase) + 1 >= per) ? '0 : phase + 1'b1;
    end else begin
      phase = '0;
    end
    s.led = lit;
    s.mode = mode;
    s.active = blinking;
    status_q.push_back(s);
  endtask

  always @(posedge clk) begin
    led_status_t want;
    if (rst) begin
      thresh = LONG_PRESS_RST;
      n_modes = MODE_COUNT_RST;
      btn_last = 1'b1;
      held = '0;
      long_seen = 1'b0;
      blinking = 1'b0;
      mode = '0;
      phase = '0;
      status_q.delete();
      results_seen = 0;
      fail_count = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (status_q.size() == 0) begin
          flag_mismatch("result item with no tick waiting for it");
        end else begin
          want = status_q.pop_front();
          if (result_mon.led_on !== want.led)
            flag_mismatch($sformatf("led_on %b, expected %b", result_mon.led_on, want.led));
          if (result_mon.current_mode !== want.mode)
            flag_mismatch($sformatf("current_mode %0d, expected %0d",
                                    result_mon.current_mode, want.mode));
          if (result_mon.blink_active !== want.active)
            flag_mismatch($sformatf("blink_active %b, expected %b",
                                    result_mon.blink_active, want.active));
        end
        results_seen++;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LONG_PRESS_TICKS: thresh = cfg_wdata[HOLD_W-1:0];
          REG_MODE_COUNT:       n_modes = cfg_wdata[MCNT_W-1:0];
          default: ;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready) step_button(tick_mon.button_level);
    end
    pending = status_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the long-press led blinker: clock, reset, register writes and
// button tick stimulus with random idling on both channels; verdict from lpbc_checker
// depends on lpbc_pkg, lpbc_if.sv, the block and test/lpbc_checker.sv
module tb_top;
  import lpbc_pkg::*;

  // longest quiet stretch is the receiver hold-off; the limit is several times that
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_TICKS    = 50;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int fail_count;
  int pending;

  // calm: no idling on either side; hold_req: ask the receiver for one long hold-off
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  // threshold and mode count per random phase: tiny thresholds so long presses are common,
  // mode counts cover zero, two to four and two values beyond four
  int phase_lpt [6] = '{2, 1, 5, 9, 3, 12};
  int phase_mc  [6] = '{4, 3, 7, 2, 0, 5};

  lpbc_in_if  tick_in ();
  lpbc_out_if result_out ();

  long_press_led_blink_controller i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tick_in    (tick_in),
    .result_out (result_out)
  );

  lpbc_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tick_mon   (tick_in),
    .result_mon (result_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one tick item and wait until it is taken; random gaps go before it,
  // valid stays high between back-to-back items
  task automatic send_tick(input logic b);
    while (!calm && $urandom_range(99) < 19) begin
      tick_in.valid <= 1'b0;
      @(posedge clk);
    end
    tick_in.valid <= 1'b1;
    tick_in.button_level <= b;
    @(posedge clk);
    while (!tick_in.ready) @(posedge clk);
  endtask

  // lo ticks pressed (level 0), then hi ticks released
  task automatic hold_then_release(input int lo, input int hi);
    repeat (lo) send_tick(1'b0);
    repeat (hi) send_tick(1'b1);
  endtask

  // stop offering, wait for every expected item, then let the result register empty
  task automatic settle();
    tick_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mode count written with junk in the unused upper bits
  task automatic write_mode_count(input int mc);
    logic [CFG_DATA_W-1:0] val;
    val = CFG_DATA_W'($urandom_range(511)) << MCNT_W;
    val[MCNT_W-1:0] = mc[MCNT_W-1:0];
    write_reg(REG_MODE_COUNT, val);
  endtask

  // mostly well-formed presses around the threshold, the rest random glitches
  task automatic random_ticks(input int budget, input int lpt);
    int sent;
    int lo;
    int hi;
    int n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(3))
          0:       lo = $urandom_range(lpt + 1, 1);       // short press
          1:       lo = lpt + 1;                          // longest short press
          2:       lo = lpt + 2;                          // shortest long press
          default: lo = lpt + $urandom_range(12, 2);      // long press
        endcase
        hi = ($urandom_range(9) == 0) ? $urandom_range(300, 40) : $urandom_range(30, 1);
        hold_then_release(lo, hi);
        sent += lo + hi;
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) send_tick(1'($urandom_range(1)));
        sent += n;
      end
    end
  endtask

  // receiver: random stalls, none while calm, one long hold-off on request
  initial begin : result_taker
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLDOFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= calm || ($urandom_range(99) >= 19);
      end
    end
  end

  // watchdog: too many cycles with no item moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (tick_in.valid && tick_in.ready) ||
          (result_out.valid && result_out.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    tick_in.valid = 1'b0;
    tick_in.button_level = 1'b1;
    result_out.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register defaults: a one-tick press toggles blinking on
    hold_then_release(1, 2);

    // threshold 1: the third held tick is a long press, two of them reach mode 2
    settle();
    write_reg(REG_LONG_PRESS_TICKS, CFG_DATA_W'(1));
    hold_then_release(4, 1);
    hold_then_release(4, 1);

    // mode count lowered below the current mode: mode holds, short press turns
    // blinking off, then a long press wraps to mode 0
    settle();
    write_mode_count(2);
    hold_then_release(1, 1);
    hold_then_release(3, 1);

    // one mode only: a long press keeps mode 0 and does not restart
    settle();
    write_mode_count(1);
    hold_then_release(3, 1);

    // random phases, with the receiver hold-off in one and no idling in another
    for (p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_LONG_PRESS_TICKS, CFG_DATA_W'(phase_lpt[p]));
      write_mode_count(phase_mc[p]);
      calm = (p == 3);
      if (p == 2) hold_req = 1'b1;
      random_ticks(PHASE_TICKS, phase_lpt[p]);
    end
    calm = 1'b0;

    // every mode in turn, each followed by a short press, so blinking runs
    // both on and off in every pattern
    settle();
    write_reg(REG_LONG_PRESS_TICKS, CFG_DATA_W'(3));
    write_mode_count(4);
    repeat (4) begin
      hold_then_release(6, 30);
      hold_then_release(2, 10);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
